/* sv/spf_pkg.sv */
// Shared types and codes for the queue-based shortest-path engine.
// No dependencies; the engine and its testbench take their names from here.
`default_nettype none
package spf_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NEG     = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         from_node;
    logic [5:0]         to_node;
    logic signed [15:0] edge_weight;
    logic [5:0]         source_node;
    logic [7:0]         scale;
  } cmd_word_t;

  typedef struct packed {
    logic [5:0]         node;
    logic signed [31:0] distance;
    logic               reached;
    logic [1:0]         status;
    logic               last;
  } res_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_INIT, S_POP, S_POPW, S_CURW, S_EDGE, S_EDGEW, S_NODEW,
    S_ORD, S_OMUL, S_OSAT
  } state_t;

endpackage
`default_nettype wire

/* sv/spf_ram.sv */
// Simple dual-port synchronous memory, one write and one registered read port.
// No dependencies.
`default_nettype none
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/queue_shortest_path_engine.sv */
// Top level of the queue-based shortest-path engine: sequencer, registers, memories.
// Depends on spf_pkg and spf_ram.
//
//  Channel  | Signals                          | Carries
//  ---------+----------------------------------+-----------------------------------
//  command  | cmd_valid, cmd_stall, cmd        | add edge, clear table, run words
//  result   | res_valid, res_stall, res        | one word per node after a run
//  config   | psel, penable, pwrite, paddr ... | node_count register at address 0
//
// Add and clear words are taken while idle. A run clears the node memory, sets up
// the source, then for each dequeued node pops it, reads the queue and the node,
// reads and checks each stored edge, relaxing one that leaves that node for a node
// in use, and ends with a final edge check. With the queue empty, each result word
// is read, scaled and saturated. Reset is synchronous and clears control state only.
// A stalled result word holds the output register and the sequencer waits.
`default_nettype none
module queue_shortest_path_engine #(
  parameter int NODES = 64,
  parameter int EDGES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire spf_pkg::cmd_word_t cmd,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output spf_pkg::res_word_t      res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  // Index widths: NW addresses a node, CW counts up to NODES inclusive.
  localparam int NW   = $clog2(NODES);
  localparam int CW   = $clog2(NODES + 1);
  localparam int EW   = $clog2(EDGES);
  localparam int ECW  = $clog2(EDGES + 1);
  localparam int NE_W = 34 + CW;   // distance, reached, queued, enqueue count
  localparam int EE_W = 28;        // from, to, weight

  spf_pkg::state_t state, state_next;

  logic [6:0]        node_count;
  logic [ECW-1:0]    edge_count;
  logic              dropped;
  logic              run_dropped;
  logic [CW-1:0]     n;
  logic [NW-1:0]     src;
  logic              src_ok;
  logic [7:0]        scale_r;
  logic [CW-1:0]     k;
  logic [NW-1:0]     head, tail, cur;
  logic [CW-1:0]     qlen;
  logic [ECW-1:0]    ei;
  logic signed [31:0] cur_dist;
  logic              neg;
  logic signed [40:0] prod;
  logic              prod_reached;

  // Memory ports.
  logic            n_we, e_we, q_we;
  logic [NW-1:0]   n_waddr, n_raddr, q_waddr, q_raddr;
  logic [NE_W-1:0] n_wdata, n_rdata;
  logic [EW-1:0]   e_waddr, e_raddr;
  logic [EE_W-1:0] e_wdata, e_rdata;
  logic [NW-1:0]   q_wdata, q_rdata;

  spf_ram #(.WIDTH(NE_W), .DEPTH(NODES)) u_node_mem (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata)
  );
  spf_ram #(.WIDTH(EE_W), .DEPTH(EDGES)) u_edge_mem (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  spf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue_mem (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  function automatic logic [NW-1:0] inc_ptr(input logic [NW-1:0] p);
    return (p == NW'(NODES - 1)) ? '0 : p + 1'b1;
  endfunction

  // Fields of the word read back from the node memory.
  logic signed [31:0] nd_dist;
  logic               nd_reach, nd_inq;
  logic [CW-1:0]      nd_cnt;
  assign nd_dist  = n_rdata[NE_W-1 -: 32];
  assign nd_reach = n_rdata[CW+1];
  assign nd_inq   = n_rdata[CW];
  assign nd_cnt   = n_rdata[CW-1:0];

  // Fields of the edge being examined.
  logic [5:0]         e_from, e_to;
  logic signed [15:0] e_w;
  assign e_from = e_rdata[27:22];
  assign e_to   = e_rdata[21:16];
  assign e_w    = e_rdata[15:0];

  logic edge_match;
  assign edge_match = (16'(e_from) == 16'(cur)) && (16'(e_to) < 16'(n));

  // Relaxation: saturated candidate and the decision on the destination node.
  logic signed [32:0] sum;
  logic signed [31:0] cand;
  logic               upd, hit_neg;
  logic [CW-1:0]      cnt_inc;
  assign sum     = 33'(cur_dist) + 33'(e_w);
  assign cand    = (sum > 33'sd2147483647)  ? 32'sh7FFFFFFF :
                   (sum < -33'sd2147483648) ? 32'sh80000000 : sum[31:0];
  assign upd     = !nd_reach || (cand < nd_dist);
  assign cnt_inc = nd_cnt + 1'b1;
  assign hit_neg = !nd_inq && (cnt_inc >= n);

  // Node count as used by a run: zero acts as one, anything above NODES as NODES.
  logic [CW-1:0] n_eff;
  assign n_eff = (node_count == 7'd0) ? CW'(1) :
                 (16'(node_count) > 16'(NODES)) ? CW'(NODES) : CW'(node_count);

  logic cmd_acc, res_free;
  assign cmd_stall = (state != spf_pkg::S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign res_free  = !res_valid || !res_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      spf_pkg::S_IDLE: begin
        if (cmd_acc && cmd.opcode == spf_pkg::OP_RUN) state_next = spf_pkg::S_CLR;
      end
      spf_pkg::S_CLR: begin
        if (k == n - 1'b1) state_next = spf_pkg::S_INIT;
      end
      spf_pkg::S_INIT:  state_next = spf_pkg::S_POP;
      spf_pkg::S_POP: begin
        state_next = (qlen == '0) ? spf_pkg::S_ORD : spf_pkg::S_POPW;
      end
      spf_pkg::S_POPW:  state_next = spf_pkg::S_CURW;
      spf_pkg::S_CURW:  state_next = spf_pkg::S_EDGE;
      spf_pkg::S_EDGE: begin
        state_next = (ei == edge_count) ? spf_pkg::S_POP : spf_pkg::S_EDGEW;
      end
      spf_pkg::S_EDGEW: begin
        state_next = edge_match ? spf_pkg::S_NODEW : spf_pkg::S_EDGE;
      end
      spf_pkg::S_NODEW: begin
        state_next = (upd && hit_neg) ? spf_pkg::S_ORD : spf_pkg::S_EDGE;
      end
      spf_pkg::S_ORD:   state_next = spf_pkg::S_OMUL;
      spf_pkg::S_OMUL:  state_next = spf_pkg::S_OSAT;
      spf_pkg::S_OSAT: begin
        if (res_free) state_next = (k == n - 1'b1) ? spf_pkg::S_IDLE : spf_pkg::S_ORD;
      end
      default: state_next = spf_pkg::S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    n_we    = 1'b0;
    n_waddr = cur;
    n_wdata = n_rdata;
    n_raddr = cur;
    e_we    = 1'b0;
    e_waddr = edge_count[EW-1:0];
    e_wdata = {cmd.from_node, cmd.to_node, cmd.edge_weight};
    e_raddr = ei[EW-1:0];
    q_we    = 1'b0;
    q_waddr = tail;
    q_wdata = NW'(e_to);
    q_raddr = head;
    case (state)
      spf_pkg::S_IDLE: begin
        e_we = cmd_acc && (cmd.opcode == spf_pkg::OP_ADD) && (edge_count < ECW'(EDGES));
      end
      spf_pkg::S_CLR: begin
        n_we    = 1'b1;
        n_waddr = k[NW-1:0];
        n_wdata = '0;
      end
      spf_pkg::S_INIT: begin
        n_we    = src_ok;
        n_waddr = src;
        n_wdata = {32'sd0, 1'b1, 1'b1, CW'(1)};
        q_we    = src_ok;
        q_waddr = '0;
        q_wdata = src;
      end
      spf_pkg::S_POPW: begin
        n_raddr = q_rdata;
      end
      spf_pkg::S_CURW: begin
        // The popped node leaves the queue.
        n_we    = 1'b1;
        n_wdata = {nd_dist, nd_reach, 1'b0, nd_cnt};
      end
      spf_pkg::S_EDGEW: begin
        n_raddr = NW'(e_to);
      end
      spf_pkg::S_NODEW: begin
        n_we    = upd;
        n_waddr = NW'(e_to);
        n_wdata = nd_inq ? {cand, 1'b1, 1'b1, nd_cnt} : {cand, 1'b1, !hit_neg, cnt_inc};
        q_we    = upd && !nd_inq && !hit_neg;
      end
      spf_pkg::S_ORD: begin
        n_raddr = k[NW-1:0];
      end
      default: ;
    endcase
  end

  // Saturated scaled distance of the word being emitted.
  logic signed [31:0] out_dist;
  assign out_dist = !prod_reached ? 32'sd0 :
                    (prod > 41'sd2147483647)  ? 32'sh7FFFFFFF :
                    (prod < -41'sd2147483648) ? 32'sh80000000 : prod[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spf_pkg::S_IDLE;
      node_count <= 7'd64;
      edge_count <= '0;
      dropped    <= 1'b0;
      res_valid  <= 1'b0;
      neg        <= 1'b0;
      qlen       <= '0;
      k          <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr[2] == spf_pkg::REG_NODE_COUNT) begin
        node_count <= pwdata[6:0];
      end
      // The emitting state loads the output register itself.
      if (res_valid && !res_stall && state != spf_pkg::S_OSAT) res_valid <= 1'b0;
      case (state)
        spf_pkg::S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.opcode)
              spf_pkg::OP_ADD: begin
                if (edge_count < ECW'(EDGES)) edge_count <= edge_count + 1'b1;
                else dropped <= 1'b1;
              end
              spf_pkg::OP_CLEAR: begin
                edge_count <= '0;
                dropped    <= 1'b0;
              end
              spf_pkg::OP_RUN: begin
                n           <= n_eff;
                src         <= NW'(cmd.source_node);
                src_ok      <= 16'(cmd.source_node) < 16'(n_eff);
                scale_r     <= cmd.scale;
                run_dropped <= dropped;
                dropped     <= 1'b0;
                neg         <= 1'b0;
                k           <= '0;
              end
              default: ;
            endcase
          end
        end
        spf_pkg::S_CLR: begin
          k <= (k == n - 1'b1) ? '0 : k + 1'b1;
        end
        spf_pkg::S_INIT: begin
          head <= '0;
          tail <= src_ok ? inc_ptr('0) : '0;
          qlen <= src_ok ? CW'(1) : '0;
        end
        spf_pkg::S_POPW: begin
          cur  <= q_rdata;
          head <= inc_ptr(head);
          qlen <= qlen - 1'b1;
        end
        spf_pkg::S_CURW: begin
          cur_dist <= nd_dist;
          ei       <= '0;
        end
        spf_pkg::S_EDGEW: begin
          if (!edge_match) ei <= ei + 1'b1;
        end
        spf_pkg::S_NODEW: begin
          ei <= ei + 1'b1;
          if (upd) begin
            // A self-loop that improves moves the distance still being relaxed from.
            if (NW'(e_to) == cur) cur_dist <= cand;
            if (!nd_inq) begin
              if (hit_neg) begin
                neg <= 1'b1;
              end else begin
                tail <= inc_ptr(tail);
                qlen <= qlen + 1'b1;
              end
            end
          end
        end
        spf_pkg::S_OMUL: begin
          prod         <= 41'(nd_dist) * 41'(signed'({1'b0, scale_r}));
          prod_reached <= nd_reach;
        end
        spf_pkg::S_OSAT: begin
          if (res_free) begin
            res_valid    <= 1'b1;
            res.node     <= 6'(k);
            res.distance <= out_dist;
            res.reached  <= prod_reached;
            res.status   <= neg ? spf_pkg::ST_NEG :
                            (run_dropped ? spf_pkg::ST_DROPPED : spf_pkg::ST_OK);
            res.last     <= (k == n - 1'b1);
            k            <= (k == n - 1'b1) ? '0 : k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == spf_pkg::REG_NODE_COUNT) ? {25'd0, node_count} : 32'd0;

endmodule
`default_nettype wire

/* verif/queue_shortest_path_engine_tb.sv */
// Self-checking testbench for the queue-based shortest-path engine.
// Depends on spf_pkg and on the engine RTL; it needs no files and no arguments.
// Commands go in from a queue, a software SPFA predicts every result word.
`timescale 1ns / 100ps
module queue_shortest_path_engine_tb;

  localparam int NODE_MAX   = 64;
  localparam int EDGE_MAX   = 256;
  localparam int ITEM_GOAL  = 330;
  localparam int CYCLE_CAP  = 6000000;
  localparam int SETTLE     = 64;
  // The one opcode that the engine ignores.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  spf_pkg::cmd_word_t cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  spf_pkg::res_word_t res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  queue_shortest_path_engine dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Commands waiting to be driven, and the result words the predictor owes us.
  spf_pkg::cmd_word_t cmd_pending[$];
  spf_pkg::res_word_t dist_words_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int item_total = 0;
  int cycle_count = 0;

  // Predictor copy of the engine's state.
  int unsigned     nodes_in_use;
  logic [5:0]      tbl_from[EDGE_MAX];
  logic [5:0]      tbl_to[EDGE_MAX];
  int              tbl_weight[EDGE_MAX];
  int unsigned     tbl_fill;
  logic            overflow_seen;
  longint          node_dist[NODE_MAX];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Apply one accepted command word to the predictor state. A run relaxes
  // edges breadth-first from the source with a FIFO of nodes and queues one
  // expected result word per node in use.
  task automatic spfa_predict(input spf_pkg::cmd_word_t c);
    int unsigned n;
    int unsigned cur;
    int unsigned dst;
    int          work[$];
    logic        reached[NODE_MAX];
    logic        queued[NODE_MAX];
    int unsigned visits[NODE_MAX];
    logic        neg_loop;
    longint      cand;
    longint      scaled;
    spf_pkg::res_word_t w;
    if (c.opcode == spf_pkg::OP_ADD) begin
      if (tbl_fill < EDGE_MAX) begin
        tbl_from[tbl_fill] = c.from_node;
        tbl_to[tbl_fill] = c.to_node;
        tbl_weight[tbl_fill] = int'(c.edge_weight);
        tbl_fill++;
      end else begin
        overflow_seen = 1'b1;
      end
    end else if (c.opcode == spf_pkg::OP_CLEAR) begin
      tbl_fill = 0;
      overflow_seen = 1'b0;
    end else if (c.opcode == spf_pkg::OP_RUN) begin
      n = nodes_in_use;
      if (n < 1) n = 1;
      if (n > NODE_MAX) n = NODE_MAX;
      neg_loop = 1'b0;
      for (int k = 0; k < NODE_MAX; k++) begin
        reached[k] = 1'b0;
        queued[k] = 1'b0;
        visits[k] = 0;
      end
      if (c.source_node < n) begin
        node_dist[c.source_node] = 0;
        reached[c.source_node] = 1'b1;
        queued[c.source_node] = 1'b1;
        visits[c.source_node] = 1;
        work.push_back(int'(c.source_node));
      end
      while (work.size() > 0 && !neg_loop) begin
        cur = work.pop_front();
        queued[cur] = 1'b0;
        for (int i = 0; i < tbl_fill && !neg_loop; i++) begin
          dst = 32'(tbl_to[i]);
          if (tbl_from[i] != cur || dst >= n) continue;
          cand = clamp32(node_dist[cur] + tbl_weight[i]);
          if (reached[dst] && cand >= node_dist[dst]) continue;
          node_dist[dst] = cand;
          reached[dst] = 1'b1;
          if (!queued[dst]) begin
            visits[dst]++;
            // Enqueued as often as there are nodes: there must be a negative loop.
            if (visits[dst] >= n) begin
              neg_loop = 1'b1;
              break;
            end
            queued[dst] = 1'b1;
            work.push_back(int'(dst));
          end
        end
      end
      w.status = neg_loop ? spf_pkg::ST_NEG :
                 (overflow_seen ? spf_pkg::ST_DROPPED : spf_pkg::ST_OK);
      overflow_seen = 1'b0;
      for (int k = 0; k < n; k++) begin
        scaled = reached[k] ? clamp32(node_dist[k] * longint'(c.scale)) : 0;
        w.node = 6'(k);
        w.distance = scaled[31:0];
        w.reached = reached[k];
        w.last = (k + 1 == n);
        dist_words_due.push_back(w);
      end
    end
  endtask

  // Command driver: the payload only moves on when the current word is taken.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) spfa_predict(cmd);
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd <= cmd_pending.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every taken word is checked against the oldest prediction.
  always @(posedge clk) begin
    spf_pkg::res_word_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (dist_words_due.size() == 0) begin
          $error("unexpected result word for node %0d", res.node);
          fail_count++;
        end else begin
          want = dist_words_due.pop_front();
          if (res.node !== want.node) begin
            $error("node: expected %0d, got %0d", want.node, res.node);
            fail_count++;
          end
          if (res.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, res.distance);
            fail_count++;
          end
          if (res.reached !== want.reached) begin
            $error("reached: expected %0d, got %0d", want.reached, res.reached);
            fail_count++;
          end
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            fail_count++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res.last);
            fail_count++;
          end
        end
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog against a hung sequencer.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [5:0] from_n,
                          input logic [5:0] to_n, input logic [15:0] wt,
                          input logic [5:0] src, input logic [7:0] scl);
    spf_pkg::cmd_word_t c;
    c.opcode = op;
    c.from_node = from_n;
    c.to_node = to_n;
    c.edge_weight = wt;
    c.source_node = src;
    c.scale = scl;
    cmd_pending.push_back(c);
    item_total++;
  endtask

  // Random filler for the fields that an operation does not use.
  task automatic push_op(input logic [1:0] op, input logic [5:0] from_n,
                         input logic [5:0] to_n, input logic [15:0] wt);
    push_cmd(op, from_n, to_n, wt, 6'($urandom_range(63)), 8'($urandom_range(255)));
  endtask

  task automatic push_run(input logic [5:0] src, input logic [7:0] scl);
    push_cmd(spf_pkg::OP_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)),
             16'($urandom), src, scl);
  endtask

  // Let every queued word go and every owed result come back, then let the
  // engine settle, since add and clear words produce nothing.
  task automatic drain;
    while (cmd_pending.size() > 0 || cmd_valid || dist_words_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write on the configuration port: setup cycle, then access cycle.
  task automatic write_node_count(input logic [6:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(spf_pkg::REG_NODE_COUNT) << 2;
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    nodes_in_use = 32'(value);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 72;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 72;
      end
      default: begin
        send_idle_pct = 17;
        recv_stall_pct = 17;
      end
    endcase
  endtask

  initial begin
    int          phase;
    int unsigned n;
    int unsigned span;
    int unsigned edges;
    logic [6:0]  nc;
    logic [15:0] wt;
    nodes_in_use = NODE_MAX;
    tbl_fill = 0;
    overflow_seen = 1'b0;
    for (int k = 0; k < NODE_MAX; k++) node_dist[k] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset node count: empty table, extreme weights,
    // a negative self-loop, the unused opcode and both extreme scales.
    push_run(6'd0, 8'd255);
    push_op(spf_pkg::OP_ADD, 6'd0, 6'd63, 16'h7fff);
    push_op(spf_pkg::OP_ADD, 6'd63, 6'd1, 16'h8000);
    push_op(spf_pkg::OP_ADD, 6'd1, 6'd2, 16'hffff);
    push_run(6'd0, 8'd255);
    push_run(6'd63, 8'd0);
    push_op(spf_pkg::OP_ADD, 6'd2, 6'd2, 16'hffff);
    push_run(6'd0, 8'd1);
    push_op(OP_SPARE, 6'd5, 6'd6, 16'h1234);
    push_op(spf_pkg::OP_CLEAR, 6'd63, 6'd63, 16'hffff);
    push_op(spf_pkg::OP_ADD, 6'd5, 6'd40, 16'd100);
    push_op(spf_pkg::OP_ADD, 6'd5, 6'd6, 16'd3);
    push_op(spf_pkg::OP_ADD, 6'd40, 6'd6, 16'h8000);
    drain();

    // Small node count with a slow sender: an out-of-range source, and edges
    // to ignored nodes.
    set_idling(1);
    write_node_count(7'd8);
    push_run(6'd40, 8'd1);
    push_run(6'd5, 8'd7);
    push_run(6'd7, 8'd2);
    drain();

    // Node count zero behaves as one node; both sides pause now and then.
    set_idling(3);
    write_node_count(7'd0);
    push_run(6'd0, 8'd9);
    push_run(6'd1, 8'd9);
    drain();

    // Full table with the receiver stalling: 255 non-negative edges among nodes
    // 0 to 2 plus a negative self-loop on node 3, then overflow words.
    set_idling(2);
    write_node_count(7'd4);
    push_op(spf_pkg::OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)),
            16'($urandom));
    for (int i = 0; i < EDGE_MAX - 1; i++)
      push_op(spf_pkg::OP_ADD, 6'($urandom_range(2)), 6'($urandom_range(2)),
              16'($urandom_range(32767)));
    push_op(spf_pkg::OP_ADD, 6'd3, 6'd3, 16'hffff);
    push_op(spf_pkg::OP_ADD, 6'd0, 6'd3, 16'd1);
    push_run(6'd0, 8'd3);
    push_run(6'd3, 8'd1);
    push_op(spf_pkg::OP_ADD, 6'd1, 6'd2, 16'd1);
    push_run(6'd3, 8'd1);
    push_run(6'd0, 8'd255);
    push_op(spf_pkg::OP_ADD, 6'd1, 6'd2, 16'd1);
    push_op(spf_pkg::OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)),
            16'($urandom));
    push_run(6'd0, 8'd1);
    drain();

    // Random graphs. Negative weights only go with small node counts so that
    // negative-loop detection stays short; the sender waits between phases.
    phase = 0;
    while (item_total < ITEM_GOAL) begin
      set_idling(phase);
      case ($urandom_range(5))
        0: nc = 7'(NODE_MAX);
        1: nc = 7'($urandom_range(127, 65));
        2: nc = 7'($urandom_range(64, 17));
        default: nc = 7'($urandom_range(16, 1));
      endcase
      write_node_count(nc);
      n = (nc == 7'd0) ? 1 : ((int'(nc) > NODE_MAX) ? NODE_MAX : int'(nc));
      for (int s = 0; s < 2; s++) begin
        push_op(spf_pkg::OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)),
                16'($urandom));
        edges = $urandom_range(24, 1);
        for (int e = 0; e < edges; e++) begin
          if (n <= 16 && $urandom_range(3) == 0) wt = 16'($urandom);
          else wt = 16'($urandom_range(32767));
          span = ($urandom_range(7) == 0) ? 63 : n - 1;
          push_op(spf_pkg::OP_ADD, 6'($urandom_range(span)), 6'($urandom_range(span)), wt);
        end
        if ($urandom_range(3) == 0)
          push_op(OP_SPARE, 6'($urandom_range(63)), 6'($urandom_range(63)), 16'($urandom));
        for (int r = $urandom_range(3, 1); r > 0; r--) begin
          span = ($urandom_range(7) == 0) ? 63 : n - 1;
          push_run(6'($urandom_range(span)), 8'($urandom_range(255)));
        end
      end
      drain();
      phase++;
    end

    // A last stretch at the top node count with no idling at all.
    set_idling(0);
    write_node_count(7'd127);
    push_run(6'd63, 8'd255);
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
